[sv/gtms_pkg.sv]
// gtms_pkg: shared types, constants and the exp table builder for the
// Metropolis step block. No dependencies; compiled first.
`default_nettype none

package gtms_pkg;

	// Field and datapath widths
	localparam int SAMPLE_W = 24;
	localparam int CFG_W    = 24;
	localparam int MUL_W    = 28;
	localparam int PROD_W   = 2 * MUL_W;
	localparam int ENTRY_W  = 31;

	// Parameter defaults
	localparam int COUNT_WIDTH_DEF    = 32;
	localparam int EXP_TABLE_BITS_DEF = 8;

	// Register reset values
	localparam logic signed [23:0] TARGET_MEAN_RST = -24'sd655360;
	localparam logic [23:0]        INV_TWO_VAR_RST = 24'd32768;
	localparam logic [15:0]        STEP_SCALE_RST  = 16'd1024;
	localparam logic signed [23:0] START_VALUE_RST = -24'sd701235;

	// log2(e) in Q.16, and the clamp on -delta (32.0 in Q.16)
	localparam logic [16:0] LOG2E_Q16 = 17'd94548;
	localparam logic [21:0] X_MAX     = 22'h200000;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_TARGET_MEAN = 2'd0,
		CFG_INV_TWO_VAR = 2'd1,
		CFG_STEP_SCALE  = 2'd2,
		CFG_START_VALUE = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic signed [23:0] target_mean;
		logic [23:0]        inv_two_var;
		logic [15:0]        step_scale;
		logic signed [23:0] start_value;
	} cfg_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_STEP,
		ST_MUL_DQ,
		ST_MUL_DP,
		ST_DIFF,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_DELTA,
		ST_EXP_MUL,
		ST_TBL_LO,
		ST_TBL_HI,
		ST_INTERP,
		ST_EXP_CMP,
		ST_COMMIT
	} state_t;

	// Integer square root, bit by bit
	function automatic longint unsigned isqrt64(longint unsigned x);
		longint unsigned res;
		longint unsigned bit_v;
		longint unsigned rem_v;
		res   = 64'd0;
		bit_v = 64'd1 << 62;
		rem_v = x;
		for (int i = 0; i < 32; i++) begin
			if (rem_v >= res + bit_v) begin
				rem_v = rem_v - (res + bit_v);
				res   = (res >> 1) + bit_v;
			end else begin
				res = res >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return res;
	endfunction

	// Entry k of the 2^(-k/2^tb) table in Q0.30; last entry is exactly 0.5
	function automatic logic [ENTRY_W-1:0] exp_entry(int tb, int k);
		longint unsigned r;
		longint unsigned e;
		r = 64'd1 << 29;
		for (int j = 0; j < tb; j++)
			r = isqrt64(r << 30);
		e = 64'd1 << 30;
		for (int j = 1; j <= k; j++)
			e = (e * r) >> 30;
		if (k >= (1 << tb))
			e = 64'd1 << 29;
		return e[ENTRY_W-1:0];
	endfunction

endpackage

`default_nettype wire

[sv/gtms_ifs.sv]
// gtms_draw_if / gtms_result_if: valid-ready channels for the draw word
// and the result word. Depends on nothing.
`default_nettype none

interface gtms_draw_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] normal_draw;
	logic [15:0]        uniform_draw;
	logic               restart;

	modport source (output valid, normal_draw, uniform_draw, restart, input ready);
	modport sink   (input valid, normal_draw, uniform_draw, restart, output ready);
endinterface

interface gtms_result_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] sample;
	logic               accepted;
	logic [31:0]        accept_count;

	modport source (output valid, sample, accepted, accept_count, input ready);
	modport sink   (input valid, sample, accepted, accept_count, output ready);
endinterface

`default_nettype wire

[sv/gaussian_target_metropolis_step.sv]
// Random-walk Metropolis step toward a Gaussian target, one item in flight.
// Draws are taken in idle; each runs the product and delta states, the exp
// states when it moves downhill, then commit, which waits for a free output.
// Throughput set by the sequence of seven products through one 28x28
// multiplier and two reads of the one-port exp table.
// Reset: arst_n clears the sequencer, loads the chain with the start value
// reset constant, zeroes the count and restores register defaults.
// Depends on gtms_pkg, gtms_ifs, gtms_cfg, gtms_mul, gtms_rom.
`default_nettype none

module gaussian_target_metropolis_step #(
	parameter int COUNT_WIDTH    = gtms_pkg::COUNT_WIDTH_DEF,
	parameter int EXP_TABLE_BITS = gtms_pkg::EXP_TABLE_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_wr_en,
	input  wire logic [1:0]                  cfg_addr,
	input  wire logic [gtms_pkg::CFG_W-1:0]  cfg_wr_data,
	gtms_draw_if.sink                        draws,
	gtms_result_if.source                    result
);

	localparam int MW = gtms_pkg::MUL_W;
	localparam int PW = gtms_pkg::PROD_W;
	localparam int EW = gtms_pkg::ENTRY_W;
	localparam int TB = EXP_TABLE_BITS;
	localparam int FS = 16 - EXP_TABLE_BITS;

	gtms_pkg::cfg_t   cfg;
	gtms_pkg::state_t state_q, state_d;

	logic signed [MW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] prod;
	logic [TB:0]          rom_addr;
	logic [EW-1:0]        rom_data;

	// Chain state and output register
	logic signed [23:0]     cur_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic                   out_valid_q;
	logic signed [23:0]     out_sample_q;
	logic                   out_acc_q;
	logic [31:0]            out_cnt_q;

	// Per-item working registers
	logic signed [15:0] nd_q;
	logic [15:0]        ud_q;
	logic signed [23:0] prop_q;
	logic [49:0]        sq_q;
	logic signed [34:0] diff_q;
	logic [40:0]        lo_q;
	logic signed [42:0] delta_q;
	logic [5:0]         n_q;
	logic [TB-1:0]      idx_q;
	logic [FS-1:0]      rem_q;
	logic [EW-1:0]      e0_q;
	logic               acc_q;

	// Combinational datapath terms
	logic signed [28:0] step29;
	logic signed [29:0] sum30;
	logic signed [23:0] prop_sat;
	logic signed [24:0] dq25, dp25;
	logic signed [50:0] diff51;
	logic signed [58:0] full59;
	logic signed [42:0] delta43;
	logic [21:0]        x22;
	logic [21:0]        y22;
	logic signed [31:0] d32;
	logic signed [PW-1:0] corr;
	logic signed [39:0] v40;
	logic [EW-1:0]      v31;
	logic [6:0]         sh7;
	logic [EW-1:0]      e31;
	logic               out_free;
	logic               commit;
	logic [COUNT_WIDTH-1:0] cnt_next;
	logic [COUNT_WIDTH+31:0] cnt_wide;

	gtms_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_wr_en),
		.addr    (cfg_addr),
		.wr_data (cfg_wr_data),
		.cfg     (cfg)
	);

	gtms_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	gtms_rom #(
		.EXP_TABLE_BITS (EXP_TABLE_BITS)
	) u_rom (
		.clk     (clk),
		.addr    (rom_addr),
		.rd_data (rom_data)
	);

	// Proposal: q + floor(step_scale * nd / 16), saturated to 24 bits
	assign step29 = prod[32:4];
	assign sum30  = {{6{cur_q[23]}}, cur_q} + {step29[28], step29};
	always_comb begin
		if (sum30[29:23] == {7{sum30[29]}})
			prop_sat = sum30[23:0];
		else if (sum30[29])
			prop_sat = {1'b1, 23'd0};
		else
			prop_sat = {1'b0, {23{1'b1}}};
	end

	// Distances from the mean
	assign dq25 = {cur_q[23], cur_q} - {cfg.target_mean[23], cfg.target_mean};
	assign dp25 = {prop_q[23], prop_q} - {cfg.target_mean[23], cfg.target_mean};

	// Difference of squares, floored to Q.16
	assign diff51 = {1'b0, sq_q} - {1'b0, prod[49:0]};

	// delta = floor(diff * inv_two_var / 2^16) from two partial products
	assign full59  = {prod[41:0], 17'd0} + {18'd0, lo_q};
	assign delta43 = full59[58:16];

	// x = min(-delta, 32.0)
	always_comb begin
		if (&delta_q[42:21])
			x22 = 22'd0 - delta_q[21:0];
		else
			x22 = gtms_pkg::X_MAX;
	end

	// y = x * log2(e), split into integer part, table index and remainder
	assign y22 = prod[37:16];

	// Table slope and interpolation
	assign d32  = {1'b0, rom_data} - {1'b0, e0_q};
	assign corr = prod >>> FS;
	assign v40  = {9'd0, e0_q} + corr[39:0];
	assign v31  = v40[39] ? '0 : v40[EW-1:0];
	assign sh7  = 7'd14 + {1'b0, n_q};
	assign e31  = v31 >> sh7;

	// Multiplier operand selection
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			gtms_pkg::ST_MUL_STEP: begin
				mul_a = {{(MW-16){1'b0}}, cfg.step_scale};
				mul_b = {{(MW-16){nd_q[15]}}, nd_q};
			end
			gtms_pkg::ST_MUL_DQ: begin
				mul_a = {{(MW-25){dq25[24]}}, dq25};
				mul_b = {{(MW-25){dq25[24]}}, dq25};
			end
			gtms_pkg::ST_MUL_DP: begin
				mul_a = {{(MW-25){dp25[24]}}, dp25};
				mul_b = {{(MW-25){dp25[24]}}, dp25};
			end
			gtms_pkg::ST_MUL_LO: begin
				mul_a = {{(MW-17){1'b0}}, diff_q[16:0]};
				mul_b = {{(MW-24){1'b0}}, cfg.inv_two_var};
			end
			gtms_pkg::ST_MUL_HI: begin
				mul_a = {{(MW-18){diff_q[34]}}, diff_q[34:17]};
				mul_b = {{(MW-24){1'b0}}, cfg.inv_two_var};
			end
			gtms_pkg::ST_EXP_MUL: begin
				mul_a = {{(MW-22){1'b0}}, x22};
				mul_b = {{(MW-17){1'b0}}, gtms_pkg::LOG2E_Q16};
			end
			gtms_pkg::ST_INTERP: begin
				mul_a = d32[MW-1:0];
				mul_b = {{(MW-FS){1'b0}}, rem_q};
			end
			default: ;
		endcase
	end

	// Table address: index on the first read, index + 1 on the second
	always_comb begin
		if (state_q == gtms_pkg::ST_TBL_LO)
			rom_addr = {1'b0, y22[15:FS]};
		else
			rom_addr = {1'b0, idx_q} + 1'b1;
	end

	// Output handoff
	assign out_free = !out_valid_q || result.ready;
	assign commit   = (state_q == gtms_pkg::ST_COMMIT) && out_free;
	assign cnt_next = (acc_q && (cnt_q != {COUNT_WIDTH{1'b1}})) ? cnt_q + 1'b1 : cnt_q;
	assign cnt_wide = {32'd0, cnt_next};

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= gtms_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			gtms_pkg::ST_IDLE:     if (draws.valid) state_d = gtms_pkg::ST_MUL_STEP;
			gtms_pkg::ST_MUL_STEP: state_d = gtms_pkg::ST_MUL_DQ;
			gtms_pkg::ST_MUL_DQ:   state_d = gtms_pkg::ST_MUL_DP;
			gtms_pkg::ST_MUL_DP:   state_d = gtms_pkg::ST_DIFF;
			gtms_pkg::ST_DIFF:     state_d = gtms_pkg::ST_MUL_LO;
			gtms_pkg::ST_MUL_LO:   state_d = gtms_pkg::ST_MUL_HI;
			gtms_pkg::ST_MUL_HI:   state_d = gtms_pkg::ST_DELTA;
			gtms_pkg::ST_DELTA: begin
				if (delta43[42])
					state_d = gtms_pkg::ST_EXP_MUL;
				else
					state_d = gtms_pkg::ST_COMMIT;
			end
			gtms_pkg::ST_EXP_MUL:  state_d = gtms_pkg::ST_TBL_LO;
			gtms_pkg::ST_TBL_LO:   state_d = gtms_pkg::ST_TBL_HI;
			gtms_pkg::ST_TBL_HI:   state_d = gtms_pkg::ST_INTERP;
			gtms_pkg::ST_INTERP:   state_d = gtms_pkg::ST_EXP_CMP;
			gtms_pkg::ST_EXP_CMP:  state_d = gtms_pkg::ST_COMMIT;
			gtms_pkg::ST_COMMIT:   if (out_free) state_d = gtms_pkg::ST_IDLE;
			default:               state_d = gtms_pkg::ST_IDLE;
		endcase
	end

	// Working registers, loaded by state
	always_ff @(posedge clk) begin
		case (state_q)
			gtms_pkg::ST_IDLE: begin
				nd_q <= draws.normal_draw;
				ud_q <= draws.uniform_draw;
			end
			gtms_pkg::ST_MUL_DQ:  prop_q <= prop_sat;
			gtms_pkg::ST_MUL_DP:  sq_q   <= prod[49:0];
			gtms_pkg::ST_DIFF:    diff_q <= diff51[50:16];
			gtms_pkg::ST_MUL_HI:  lo_q   <= prod[40:0];
			gtms_pkg::ST_DELTA: begin
				delta_q <= delta43;
				acc_q   <= 1'b1;
			end
			gtms_pkg::ST_TBL_LO: begin
				n_q   <= y22[21:16];
				idx_q <= y22[15:FS];
				rem_q <= y22[FS-1:0];
			end
			gtms_pkg::ST_TBL_HI:  e0_q  <= rom_data;
			gtms_pkg::ST_EXP_CMP: acc_q <= ({15'd0, ud_q} < e31);
			default: ;
		endcase
	end

	// Chain state: restart on acceptance, update on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= gtms_pkg::START_VALUE_RST;
			cnt_q <= '0;
		end else if (draws.valid && draws.ready && draws.restart) begin
			cur_q <= cfg.start_value;
			cnt_q <= '0;
		end else if (commit) begin
			if (acc_q)
				cur_q <= prop_q;
			cnt_q <= cnt_next;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (commit)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_sample_q <= acc_q ? prop_q : cur_q;
			out_acc_q    <= acc_q;
			out_cnt_q    <= cnt_wide[31:0];
		end
	end

	assign draws.ready         = (state_q == gtms_pkg::ST_IDLE);
	assign result.valid        = out_valid_q;
	assign result.sample       = out_sample_q;
	assign result.accepted     = out_acc_q;
	assign result.accept_count = out_cnt_q;

endmodule

`default_nettype wire

[sv/gtms_cfg.sv]
// gtms_cfg: configuration register file with plain write port.
// Depends on gtms_pkg.
`default_nettype none

module gtms_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        wr_en,
	input  wire logic [1:0]                  addr,
	input  wire logic [gtms_pkg::CFG_W-1:0]  wr_data,
	output gtms_pkg::cfg_t                   cfg
);

	gtms_pkg::cfg_t cfg_q;

	// Register writes; unknown indexes cannot occur with a 2-bit index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_mean <= gtms_pkg::TARGET_MEAN_RST;
			cfg_q.inv_two_var <= gtms_pkg::INV_TWO_VAR_RST;
			cfg_q.step_scale  <= gtms_pkg::STEP_SCALE_RST;
			cfg_q.start_value <= gtms_pkg::START_VALUE_RST;
		end else if (wr_en) begin
			case (addr)
				gtms_pkg::CFG_TARGET_MEAN: cfg_q.target_mean <= wr_data;
				gtms_pkg::CFG_INV_TWO_VAR: cfg_q.inv_two_var <= wr_data;
				gtms_pkg::CFG_STEP_SCALE:  cfg_q.step_scale  <= wr_data[15:0];
				gtms_pkg::CFG_START_VALUE: cfg_q.start_value <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[sv/gtms_mul.sv]
// gtms_mul: shared signed multiplier with registered product.
// Depends on gtms_pkg.
`default_nettype none

module gtms_mul (
	input  wire logic                               clk,
	input  wire logic signed [gtms_pkg::MUL_W-1:0]  a,
	input  wire logic signed [gtms_pkg::MUL_W-1:0]  b,
	output logic signed [gtms_pkg::PROD_W-1:0]      p
);

	logic signed [gtms_pkg::PROD_W-1:0] p_q;

	// One product per cycle; the product is ready in the cycle after its operands
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule

`default_nettype wire

[sv/gtms_rom.sv]
// gtms_rom: constant 2^(-k/2^TB) table in Q0.30, one registered read port.
// Depends on gtms_pkg (exp_entry builder).
`default_nettype none

module gtms_rom #(
	parameter int EXP_TABLE_BITS = gtms_pkg::EXP_TABLE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic [EXP_TABLE_BITS:0]       addr,
	output logic [gtms_pkg::ENTRY_W-1:0]       rd_data
);

	localparam int DEPTH = (1 << EXP_TABLE_BITS) + 1;

	logic [gtms_pkg::ENTRY_W-1:0] tbl [DEPTH];
	logic [gtms_pkg::ENTRY_W-1:0] rd_q;

	// Entries are elaboration-time constants
	for (genvar k = 0; k < DEPTH; k++) begin : g_ent
		localparam logic [gtms_pkg::ENTRY_W-1:0] ENT = gtms_pkg::exp_entry(EXP_TABLE_BITS, k);
		assign tbl[k] = ENT;
	end

	always_ff @(posedge clk) begin
		rd_q <= tbl[addr];
	end

	assign rd_data = rd_q;

endmodule

`default_nettype wire
